// File: rtl/qfhw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfhw_pkg
// Shared types, frame kind codes, type byte constants and varint helpers
// for the QUIC frame header writer.
// ----------------------------------------------------------------------------
package qfhw_pkg;

  // Frame request, one transfer on the command side
  typedef struct packed {
    logic [3:0]  req_type;
    logic [61:0] first_value;
    logic [61:0] second_value;
    logic [61:0] third_value;
    logic [63:0] path_data;
    logic        fin_flag;
    logic        bidirectional;
  } req_t;

  // One header byte, one transfer on the result side
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } result_t;

  typedef enum logic [3:0] {
    KIND_CRYPTO          = 4'd0,
    KIND_CLOSE           = 4'd1,
    KIND_RETIRE_CID      = 4'd2,
    KIND_PATH_RESP       = 4'd3,
    KIND_PATH_CHAL       = 4'd4,
    KIND_DATAGRAM        = 4'd5,
    KIND_STREAM          = 4'd6,
    KIND_RESET           = 4'd7,
    KIND_STOP            = 4'd8,
    KIND_MAX_DATA        = 4'd9,
    KIND_MAX_STREAM_DATA = 4'd10,
    KIND_DATA_BLOCKED    = 4'd11,
    KIND_STREAM_DATA_BLK = 4'd12,
    KIND_STREAMS_BLOCKED = 4'd13,
    KIND_MAX_STREAMS     = 4'd14,
    KIND_NEW_CID         = 4'd15
  } kind_t;

  localparam logic [7:0] TYPE_CRYPTO          = 8'h06;
  localparam logic [7:0] TYPE_CLOSE           = 8'h1c;
  localparam logic [7:0] TYPE_RETIRE_CID      = 8'h19;
  localparam logic [7:0] TYPE_PATH_RESP       = 8'h1b;
  localparam logic [7:0] TYPE_PATH_CHAL       = 8'h1a;
  localparam logic [7:0] TYPE_DATAGRAM        = 8'h31;
  localparam logic [7:0] TYPE_STREAM_BASE     = 8'h0a;
  localparam logic [7:0] TYPE_STREAM_OFF      = 8'h04;
  localparam logic [7:0] TYPE_STREAM_FIN      = 8'h01;
  localparam logic [7:0] TYPE_RESET           = 8'h04;
  localparam logic [7:0] TYPE_STOP            = 8'h05;
  localparam logic [7:0] TYPE_MAX_DATA        = 8'h10;
  localparam logic [7:0] TYPE_MAX_STREAM_DATA = 8'h11;
  localparam logic [7:0] TYPE_DATA_BLOCKED    = 8'h14;
  localparam logic [7:0] TYPE_STREAM_DATA_BLK = 8'h15;
  localparam logic [7:0] TYPE_STREAMS_BLK_BI  = 8'h16;
  localparam logic [7:0] TYPE_STREAMS_BLK_UNI = 8'h17;
  localparam logic [7:0] TYPE_MAX_STREAMS_BI  = 8'h12;
  localparam logic [7:0] TYPE_MAX_STREAMS_UNI = 8'h13;
  localparam logic [7:0] TYPE_NEW_CID         = 8'h18;

  localparam int NUM_SLOTS = 4;

  // One header segment: up to 8 bytes, sent MSB first, last_idx = length - 1
  typedef struct packed {
    logic        used;
    logic [2:0]  last_idx;
    logic [63:0] value;
  } slot_t;

  typedef struct packed {
    slot_t [NUM_SLOTS-1:0] slot;
  } plan_t;

  localparam slot_t SLOT_NONE = '{used: 1'b0, last_idx: 3'd0, value: 64'd0};

  // Minimal-length QUIC varint
  function automatic slot_t varint(input logic [61:0] v);
    slot_t s;
    s.used = 1'b1;
    if (v < 62'd64) begin
      s.last_idx = 3'd0;
      s.value    = {56'd0, 2'b00, v[5:0]};
    end else if (v < 62'd16384) begin
      s.last_idx = 3'd1;
      s.value    = {48'd0, 2'b01, v[13:0]};
    end else if (v < 62'd1073741824) begin
      s.last_idx = 3'd3;
      s.value    = {32'd0, 2'b10, v[29:0]};
    end else begin
      s.last_idx = 3'd7;
      s.value    = {2'b11, v};
    end
    return s;
  endfunction

  function automatic slot_t raw_byte(input logic [7:0] b);
    slot_t s;
    s.used     = 1'b1;
    s.last_idx = 3'd0;
    s.value    = {56'd0, b};
    return s;
  endfunction

  function automatic slot_t raw_path(input logic [63:0] d);
    slot_t s;
    s.used     = 1'b1;
    s.last_idx = 3'd7;
    s.value    = d;
    return s;
  endfunction

endpackage

// File: rtl/qfhw_plan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfhw_plan
// Decodes a frame request into up to four header segments.
// ----------------------------------------------------------------------------
module qfhw_plan (
  input  qfhw_pkg::req_t  req,
  output qfhw_pkg::plan_t plan
);

  logic [7:0] stream_type;

  always_comb begin
    stream_type = qfhw_pkg::TYPE_STREAM_BASE;
    if (req.second_value != '0) stream_type = stream_type | qfhw_pkg::TYPE_STREAM_OFF;
    if (req.fin_flag)           stream_type = stream_type | qfhw_pkg::TYPE_STREAM_FIN;
  end

  always_comb begin
    plan.slot[0] = qfhw_pkg::SLOT_NONE;
    plan.slot[1] = qfhw_pkg::SLOT_NONE;
    plan.slot[2] = qfhw_pkg::SLOT_NONE;
    plan.slot[3] = qfhw_pkg::SLOT_NONE;
    unique case (qfhw_pkg::kind_t'(req.req_type))
      qfhw_pkg::KIND_CRYPTO: begin
        plan.slot[0] = qfhw_pkg::raw_byte(qfhw_pkg::TYPE_CRYPTO);
        plan.slot[1] = qfhw_pkg::varint(req.second_value);
        plan.slot[2] = qfhw_pkg::varint(req.third_value);
      end
      qfhw_pkg::KIND_CLOSE: begin
        plan.slot[0] = qfhw_pkg::raw_byte(qfhw_pkg::TYPE_CLOSE);
        plan.slot[1] = qfhw_pkg::varint(req.first_value);
        plan.slot[2] = qfhw_pkg::varint(req.second_value);
        plan.slot[3] = qfhw_pkg::varint(req.third_value);
      end
      qfhw_pkg::KIND_RETIRE_CID: begin
        plan.slot[0] = qfhw_pkg::raw_byte(qfhw_pkg::TYPE_RETIRE_CID);
        plan.slot[1] = qfhw_pkg::varint(req.first_value);
      end
      qfhw_pkg::KIND_PATH_RESP: begin
        plan.slot[0] = qfhw_pkg::raw_byte(qfhw_pkg::TYPE_PATH_RESP);
        plan.slot[1] = qfhw_pkg::raw_path(req.path_data);
      end
      qfhw_pkg::KIND_PATH_CHAL: begin
        plan.slot[0] = qfhw_pkg::raw_byte(qfhw_pkg::TYPE_PATH_CHAL);
        plan.slot[1] = qfhw_pkg::raw_path(req.path_data);
      end
      qfhw_pkg::KIND_DATAGRAM: begin
        plan.slot[0] = qfhw_pkg::raw_byte(qfhw_pkg::TYPE_DATAGRAM);
        plan.slot[1] = qfhw_pkg::varint(req.third_value);
      end
      qfhw_pkg::KIND_STREAM: begin
        plan.slot[0] = qfhw_pkg::raw_byte(stream_type);
        plan.slot[1] = qfhw_pkg::varint(req.first_value);
        // zero offset is left out; empty slot is skipped by the serializer
        if (req.second_value != '0) plan.slot[2] = qfhw_pkg::varint(req.second_value);
        plan.slot[3] = qfhw_pkg::varint(req.third_value);
      end
      qfhw_pkg::KIND_RESET: begin
        plan.slot[0] = qfhw_pkg::raw_byte(qfhw_pkg::TYPE_RESET);
        plan.slot[1] = qfhw_pkg::varint(req.first_value);
        plan.slot[2] = qfhw_pkg::varint(req.second_value);
        plan.slot[3] = qfhw_pkg::varint(req.third_value);
      end
      qfhw_pkg::KIND_STOP: begin
        plan.slot[0] = qfhw_pkg::raw_byte(qfhw_pkg::TYPE_STOP);
        plan.slot[1] = qfhw_pkg::varint(req.first_value);
        plan.slot[2] = qfhw_pkg::varint(req.second_value);
      end
      qfhw_pkg::KIND_MAX_DATA: begin
        plan.slot[0] = qfhw_pkg::raw_byte(qfhw_pkg::TYPE_MAX_DATA);
        plan.slot[1] = qfhw_pkg::varint(req.second_value);
      end
      qfhw_pkg::KIND_MAX_STREAM_DATA: begin
        plan.slot[0] = qfhw_pkg::raw_byte(qfhw_pkg::TYPE_MAX_STREAM_DATA);
        plan.slot[1] = qfhw_pkg::varint(req.first_value);
        plan.slot[2] = qfhw_pkg::varint(req.second_value);
      end
      qfhw_pkg::KIND_DATA_BLOCKED: begin
        plan.slot[0] = qfhw_pkg::raw_byte(qfhw_pkg::TYPE_DATA_BLOCKED);
        plan.slot[1] = qfhw_pkg::varint(req.second_value);
      end
      qfhw_pkg::KIND_STREAM_DATA_BLK: begin
        plan.slot[0] = qfhw_pkg::raw_byte(qfhw_pkg::TYPE_STREAM_DATA_BLK);
        plan.slot[1] = qfhw_pkg::varint(req.first_value);
        plan.slot[2] = qfhw_pkg::varint(req.second_value);
      end
      qfhw_pkg::KIND_STREAMS_BLOCKED: begin
        plan.slot[0] = qfhw_pkg::raw_byte(req.bidirectional ?
                                          qfhw_pkg::TYPE_STREAMS_BLK_BI :
                                          qfhw_pkg::TYPE_STREAMS_BLK_UNI);
        plan.slot[1] = qfhw_pkg::varint(req.second_value);
      end
      qfhw_pkg::KIND_MAX_STREAMS: begin
        plan.slot[0] = qfhw_pkg::raw_byte(req.bidirectional ?
                                          qfhw_pkg::TYPE_MAX_STREAMS_BI :
                                          qfhw_pkg::TYPE_MAX_STREAMS_UNI);
        plan.slot[1] = qfhw_pkg::varint(req.second_value);
      end
      qfhw_pkg::KIND_NEW_CID: begin
        plan.slot[0] = qfhw_pkg::raw_byte(qfhw_pkg::TYPE_NEW_CID);
        plan.slot[1] = qfhw_pkg::varint(req.first_value);
        plan.slot[2] = qfhw_pkg::varint(req.second_value);
        plan.slot[3] = qfhw_pkg::raw_byte(req.third_value[7:0]);
      end
    endcase
  end

endmodule

// File: rtl/qfhw_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfhw_serial
// Holds the segment plan and sends it one byte per cycle through an
// output register; takes the next plan on the final byte.
// ----------------------------------------------------------------------------
module qfhw_serial (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  qfhw_pkg::plan_t   plan,
  output logic              busy,
  output logic              strobe,
  output qfhw_pkg::result_t result
);

  qfhw_pkg::plan_t plan_q;
  logic            active;
  logic [1:0]      cur;
  logic [2:0]      idx;

  qfhw_pkg::slot_t cur_slot;
  logic [2:0]      byte_sel;
  logic [7:0]      cur_byte;
  logic            slot_done;
  logic            has_next;
  logic [1:0]      next_slot;
  logic            at_last;
  logic            load;

  always_comb begin
    cur_slot  = plan_q.slot[cur];
    byte_sel  = cur_slot.last_idx - idx;
    cur_byte  = cur_slot.value[{byte_sel, 3'b000} +: 8];
    slot_done = (idx == cur_slot.last_idx);
    // first used slot after the current one
    has_next  = 1'b0;
    next_slot = cur;
    for (int i = qfhw_pkg::NUM_SLOTS - 1; i >= 1; i--) begin
      if ((2'(i) > cur) && plan_q.slot[i].used) begin
        has_next  = 1'b1;
        next_slot = 2'(i);
      end
    end
    at_last = active && slot_done && !has_next;
    busy    = active && !at_last;
    load    = start && !busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
      cur    <= '0;
      idx    <= '0;
    end else begin
      strobe <= active;
      if (load) begin
        active <= 1'b1;
        cur    <= '0;
        idx    <= '0;
      end else if (active) begin
        if (at_last) begin
          active <= 1'b0;
        end else if (slot_done) begin
          cur <= next_slot;
          idx <= '0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) plan_q <= plan;
    if (active) begin
      result.out_byte  <= cur_byte;
      result.last_byte <= at_last;
    end
  end

endmodule

// File: rtl/quic_frame_header_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quic_frame_header_writer_core
// Encodes one QUIC frame request into its header bytes, one byte per cycle.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload            transfer when
//  --------  ---------------  -----------------  -------------------------
//  request   start / busy     req    (req_t)     start && !busy at clk edge
//  result    strobe           result (result_t)  every cycle strobe is high
//
//  Flow: a frame has N header bytes (2 to 25), busy high up to the last;
//  one byte leaves per cycle from the serializer's byte counter, and busy
//  drops on the final byte so the next request is taken in that cycle.
//  Order: the request is registered, then bytes leave the output register.
//  Reset: synchronous, clears the serializer state and the strobe.
//  Stalls: none on the result side; the receiver takes every strobed byte.
//
// Structure:
//  qfhw_plan   - splits the request into up to four segments (type byte,
//                varints, path bytes, raw cid length byte); a zero stream
//                offset leaves an empty segment that is skipped.
//  qfhw_serial - registers the plan on transfer and walks the segments,
//                most significant byte first, into the result register.
// ----------------------------------------------------------------------------
module quic_frame_header_writer_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  qfhw_pkg::req_t    req,
  output logic              busy,
  output logic              strobe,
  output qfhw_pkg::result_t result
);

  qfhw_pkg::plan_t plan;

  // Segment decode straight off the request ports; registered on transfer
  qfhw_plan u_plan (
    .req  (req),
    .plan (plan)
  );

  // Byte walker plus output register
  qfhw_serial u_serial (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .plan   (plan),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

endmodule

// File: rtl/qfhw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfhw_checker
// Port-level checks on request/result timing of the header writer.
// ----------------------------------------------------------------------------
module qfhw_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input qfhw_pkg::result_t result
);

  // a request transfer is followed by a strobed byte
  a_first_byte: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 strobe)
    else $error("no byte after request transfer");

  // while busy, a byte is always on its way
  a_busy_strobe: assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe)
    else $error("busy without byte output");

  // bytes of one frame are contiguous
  a_contig: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_byte |=> strobe)
    else $error("gap inside frame header");

  // idle with no request stays idle
  a_idle: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> !busy)
    else $error("busy raised without request");

endmodule

bind quic_frame_header_writer_core qfhw_checker u_qfhw_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);
